// File: sv/ovl_pkg.sv
package ovl_pkg;

    localparam int DATA_W = 32;
    localparam int HELD_W = 5;

    typedef enum logic [1:0] {
        MODE_APPEND = 2'd0,
        MODE_SEARCH = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_DUMP   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_FOUND    = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_FULL     = 3'd4,
        ST_ENTRY    = 3'd5
    } status_t;

endpackage

// File: sv/ovl_ram.sv
module ovl_ram
    import ovl_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/ordered_value_list.sv
// Append, and any operation on an empty list, gives its single result in the cycle after the item is taken.
// Search reads one entry a cycle through the memory read port.
// Remove scans from the tail, then moves each later entry down one place.
// Dump gives one result a cycle once the first entry has been read, slowed only by a stalled output.
// A new item is taken only once the previous one is finished and the output register is free.
// Reset clears the entry count, the handshake state and the output registers, not the memory.
module ordered_value_list
    import ovl_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               mode,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [2:0]               status,
    output logic signed [DATA_W-1:0] entry_value,
    output logic [HELD_W-1:0]        entries_held,
    output logic                     last
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SCAN,
        S_SHIFT,
        S_DUMP
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [DATA_W-1:0]   key_reg, key_next;
    logic                out_valid_reg, out_valid_next;
    status_t             status_reg, status_next;
    logic [DATA_W-1:0]   entry_value_reg, entry_value_next;
    logic [HELD_W-1:0]   held_reg, held_next;
    logic                last_reg, last_next;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [DATA_W-1:0]   mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic [DATA_W-1:0]   mem_rdata;

    logic                out_free;
    logic                accept;
    logic                full;
    logic                empty;
    logic [AW-1:0]       tail_idx;
    logic                at_tail;
    logic                match;
    logic [CW-1:0]       count_dec;

    ovl_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && out_free;
    assign accept    = in_valid && in_ready;
    assign full      = (count_reg == CW'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign count_dec = count_reg - CW'(1);
    assign tail_idx  = AW'(count_dec);
    assign at_tail   = (idx_reg == tail_idx);
    assign match     = (mem_rdata == key_reg);

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        count_next       = count_reg;
        key_next         = key_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        status_next      = status_reg;
        entry_value_next = entry_value_reg;
        held_next        = held_reg;
        last_next        = last_reg;
        mem_we           = 1'b0;
        mem_waddr        = '0;
        mem_wdata        = '0;
        mem_re           = 1'b0;
        mem_raddr        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    key_next         = value;
                    entry_value_next = '0;
                    last_next        = 1'b1;
                    held_next        = HELD_W'(count_reg);
                    if (mode_t'(mode) == MODE_APPEND)
                    begin
                        out_valid_next = 1'b1;
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            mem_we      = 1'b1;
                            mem_waddr   = AW'(count_reg);
                            mem_wdata   = value;
                            count_next  = count_reg + CW'(1);
                            held_next   = HELD_W'(count_reg + CW'(1));
                            status_next = ST_DONE;
                        end
                    end
                    else if (empty)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = ST_EMPTY;
                    end
                    else if (mode_t'(mode) == MODE_REMOVE)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = tail_idx;
                        idx_next   = tail_idx;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = '0;
                        idx_next   = '0;
                        state_next = (mode_t'(mode) == MODE_SEARCH) ? S_SEARCH : S_DUMP;
                    end
                end
            end

            S_SEARCH:
            begin
                if (match || at_tail)
                begin
                    out_valid_next = 1'b1;
                    status_next    = match ? ST_FOUND : ST_NOTFOUND;
                    state_next     = S_IDLE;
                end
                else
                begin
                    idx_next  = idx_reg + AW'(1);
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg + AW'(1);
                end
            end

            S_SCAN:
            begin
                if (match)
                begin
                    if (at_tail)
                    begin
                        count_next     = count_dec;
                        held_next      = HELD_W'(count_dec);
                        out_valid_next = 1'b1;
                        status_next    = ST_DONE;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        mem_re     = 1'b1;
                        mem_raddr  = idx_reg + AW'(1);
                        state_next = S_SHIFT;
                    end
                end
                else if (idx_reg == '0)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_NOTFOUND;
                    state_next     = S_IDLE;
                end
                else
                begin
                    idx_next  = idx_reg - AW'(1);
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg - AW'(1);
                end
            end

            S_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg - AW'(1);
                mem_wdata = mem_rdata;
                if (at_tail)
                begin
                    count_next     = count_dec;
                    held_next      = HELD_W'(count_dec);
                    out_valid_next = 1'b1;
                    status_next    = ST_DONE;
                    state_next     = S_IDLE;
                end
                else
                begin
                    idx_next  = idx_reg + AW'(1);
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg + AW'(1);
                end
            end

            S_DUMP:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = ST_ENTRY;
                    entry_value_next = mem_rdata;
                    held_next        = HELD_W'(count_reg);
                    last_next        = at_tail;
                    if (at_tail)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next  = idx_reg + AW'(1);
                        mem_re    = 1'b1;
                        mem_raddr = idx_reg + AW'(1);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
            idx_reg         <= '0;
            key_reg         <= '0;
            status_reg      <= ST_DONE;
            entry_value_reg <= '0;
            held_reg        <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            out_valid_reg   <= out_valid_next;
            idx_reg         <= idx_next;
            key_reg         <= key_next;
            status_reg      <= status_next;
            entry_value_reg <= entry_value_next;
            held_reg        <= held_next;
            last_reg        <= last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign entry_value  = entry_value_reg;
    assign entries_held = held_reg;
    assign last         = last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode_t'(mode) == MODE_APPEND && !full)
        |=> (count_reg == $past(count_reg) + CW'(1)))
    else $error("append did not grow the list");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (idx_reg != '0))
    else $error("shift step at the head position");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_ENTRY && last_reg) |-> (state_reg == S_IDLE))
    else $error("final dumped item shown while the dump is still running");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !empty)
    else $error("list walk on an empty list");

endmodule
